// ===== rtl/core/tlpt_pkg.sv =====
// ----------------------------------------------------------------------------
// tlpt_pkg
// Shared types and constants of the three level page table walk: opcodes,
// status codes, descriptor bits and field widths.
// ----------------------------------------------------------------------------
package tlpt_pkg;

  localparam int VA_W          = 39;
  localparam int PA_W          = 48;
  localparam int PAGE_W        = 36;   // physical page number, bits 47:12
  localparam int DESC_W        = 64;
  localparam int IDX_W         = 9;
  localparam int TABLE_ENTRIES = 512;

  localparam logic [1:0] OP_MAP       = 2'd0;
  localparam logic [1:0] OP_UNMAP     = 2'd1;
  localparam logic [1:0] OP_TRANSLATE = 2'd2;
  localparam logic [1:0] OP_UNUSED    = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_ALIGN    = 2'd1;
  localparam logic [1:0] ST_UNMAPPED = 2'd2;
  localparam logic [1:0] ST_NOTABLE  = 2'd3;

  localparam int FL_WRITE  = 0;
  localparam int FL_EXEC   = 1;
  localparam int FL_USER   = 2;
  localparam int FL_DEVICE = 3;

  localparam logic [DESC_W-1:0] D_VALID       = 64'h1;
  localparam logic [DESC_W-1:0] D_TABLE       = 64'h1 << 1;
  localparam logic [DESC_W-1:0] D_ATTR_NORMAL = 64'h1 << 2;
  localparam logic [DESC_W-1:0] D_AP_USER     = 64'h1 << 6;
  localparam logic [DESC_W-1:0] D_AP_RO       = 64'h1 << 7;
  localparam logic [DESC_W-1:0] D_SH_INNER    = 64'h3 << 8;
  localparam logic [DESC_W-1:0] D_AF          = 64'h1 << 10;
  localparam logic [DESC_W-1:0] D_NG          = 64'h1 << 11;
  localparam logic [DESC_W-1:0] D_PXN         = 64'h1 << 53;
  localparam logic [DESC_W-1:0] D_UXN         = 64'h1 << 54;

  // Decode of a table descriptor read from the store.
  typedef struct packed {
    logic present;    // valid bit set
    logic in_range;   // points at a table already taken
  } link_info_t;

endpackage

// ===== rtl/core/tlpt_if.sv =====
// ----------------------------------------------------------------------------
// tlpt_if
// Valid/ready channels of the page table walk: request, response and the
// table base configuration write.
// ----------------------------------------------------------------------------
interface tlpt_in_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   opcode;
  logic [tlpt_pkg::VA_W-1:0]    virt_addr;
  logic [tlpt_pkg::PA_W-1:0]    phys_addr_in;
  logic [3:0]                   map_flags;

  modport source (output valid, opcode, virt_addr, phys_addr_in, map_flags, input ready);
  modport sink   (input valid, opcode, virt_addr, phys_addr_in, map_flags, output ready);
endinterface

interface tlpt_out_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   status;
  logic [tlpt_pkg::PA_W-1:0]    phys_addr_out;
  logic [tlpt_pkg::DESC_W-1:0]  leaf_entry;

  modport source (output valid, status, phys_addr_out, leaf_entry, input ready);
  modport sink   (input valid, status, phys_addr_out, leaf_entry, output ready);
endinterface

interface tlpt_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [tlpt_pkg::PA_W-1:0]    data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ===== rtl/core/tlpt_store.sv =====
// ----------------------------------------------------------------------------
// tlpt_store
// Page table memory: one write and one registered read port, with a
// clearing pass over every entry after reset.
// ----------------------------------------------------------------------------
module tlpt_store #(
  parameter int ADDR_W = 15,
  parameter int DEPTH  = 32768
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        rd_en,
  input  logic [ADDR_W-1:0]           rd_addr,
  output logic [tlpt_pkg::DESC_W-1:0] rd_data,
  input  logic                        wr_en,
  input  logic [ADDR_W-1:0]           wr_addr,
  input  logic [tlpt_pkg::DESC_W-1:0] wr_data,
  output logic                        clearing
);

  logic [tlpt_pkg::DESC_W-1:0] mem [DEPTH];
  logic [ADDR_W-1:0]           clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      clearing <= 1'b1;
    end else if (clearing) begin
      clr_addr <= clr_addr + ADDR_W'(1);
      if (clr_addr == ADDR_W'(DEPTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // The sweep owns the write port until every entry reads as zero.
  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/core/tlpt_desc.sv =====
// ----------------------------------------------------------------------------
// tlpt_desc
// Descriptor logic: decodes a table descriptor to a table number, builds
// the link to the next free table and the leaf for a map word.
// ----------------------------------------------------------------------------
module tlpt_desc #(
  parameter int TAB_W  = 6,
  parameter int USED_W = 7
) (
  input  logic [tlpt_pkg::DESC_W-1:0] entry,
  input  logic [tlpt_pkg::PA_W-1:0]   base,
  input  logic [USED_W-1:0]           used,
  input  logic [tlpt_pkg::PA_W-1:0]   pa,
  input  logic [3:0]                  flags,
  output tlpt_pkg::link_info_t        link,
  output logic [TAB_W-1:0]            target,
  output logic [tlpt_pkg::DESC_W-1:0] new_link,
  output logic [tlpt_pkg::DESC_W-1:0] leaf
);

  logic [tlpt_pkg::PAGE_W-1:0] offset;
  logic [tlpt_pkg::PAGE_W-1:0] link_page;
  logic                        wr, ex, us, dev;

  // Table numbers are page offsets from the base, modulo the 48-bit space.
  assign offset        = entry[47:12] - base[47:12];
  assign link.present  = entry[0];
  assign link.in_range = offset < tlpt_pkg::PAGE_W'(used);
  assign target        = offset[TAB_W-1:0];

  assign link_page = base[47:12] + tlpt_pkg::PAGE_W'(used);
  assign new_link  = {16'b0, link_page, 12'b0} | tlpt_pkg::D_VALID | tlpt_pkg::D_TABLE;

  assign wr  = flags[tlpt_pkg::FL_WRITE];
  assign ex  = flags[tlpt_pkg::FL_EXEC];
  assign us  = flags[tlpt_pkg::FL_USER];
  assign dev = flags[tlpt_pkg::FL_DEVICE];

  always_comb begin
    leaf = {16'b0, pa[47:12], 12'b0} | tlpt_pkg::D_VALID | tlpt_pkg::D_TABLE | tlpt_pkg::D_AF;
    if (dev) begin
      leaf = leaf | tlpt_pkg::D_PXN | tlpt_pkg::D_UXN;
    end else begin
      leaf = leaf | tlpt_pkg::D_ATTR_NORMAL | tlpt_pkg::D_SH_INNER;
    end
    if (us) begin
      leaf = leaf | tlpt_pkg::D_AP_USER | tlpt_pkg::D_NG;
    end
    if (!wr) begin
      leaf = leaf | tlpt_pkg::D_AP_RO;
    end
    if (!ex) begin
      leaf = leaf | tlpt_pkg::D_PXN | tlpt_pkg::D_UXN;
    end else if (!us) begin
      leaf = leaf | tlpt_pkg::D_UXN;
    end
  end

endmodule

// ===== rtl/core/three_level_page_table_map_walk.sv =====
// ----------------------------------------------------------------------------
// three_level_page_table_map_walk
// Map, unmap and translate over a three level store of 512-entry page
// tables, with second and third level tables taken from a bump counter.
// ----------------------------------------------------------------------------
//   port   dir   carries
//   req    in    opcode, virt_addr, phys_addr_in, map_flags
//   rsp    out   status, phys_addr_out, leaf_entry
//   cfg    in    table base address (48 bits)
//
// A walk makes one memory read per level, each answered in the cycle after
// it on the single read port. Misaligned maps and the unused opcode go from
// accept straight to the done state. After reset a clearing pass writes zero
// to all MAX_TABLES*512 entries, one per cycle, before req is ready. A result
// waits in the output register while the next word is accepted; a walk that
// ends before that result is taken holds in its final state.
// ----------------------------------------------------------------------------
module three_level_page_table_map_walk #(
  parameter int MAX_TABLES = 64
) (
  input  logic       clk,
  input  logic       rst,
  tlpt_in_if.sink    req,
  tlpt_out_if.source rsp,
  tlpt_cfg_if.sink   cfg
);

  localparam int TAB_W  = $clog2(MAX_TABLES);
  localparam int USED_W = $clog2(MAX_TABLES + 1);
  localparam int ADDR_W = TAB_W + tlpt_pkg::IDX_W;
  localparam int DEPTH  = MAX_TABLES * tlpt_pkg::TABLE_ENTRIES;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_L1   = 3'd1;
  localparam logic [2:0] S_L2   = 3'd2;
  localparam logic [2:0] S_LEAF = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]                  state, state_next;
  logic [tlpt_pkg::PA_W-1:0]   base;
  logic [USED_W-1:0]           used, used_next;
  logic [ADDR_W-1:0]           addr, addr_next;
  logic [1:0]                  op;
  logic [tlpt_pkg::VA_W-1:0]   va;
  logic [tlpt_pkg::PA_W-1:0]   pa;
  logic [3:0]                  flags;
  logic [1:0]                  res_status, res_status_next;
  logic [tlpt_pkg::PA_W-1:0]   res_pa, res_pa_next;
  logic [tlpt_pkg::DESC_W-1:0] res_leaf, res_leaf_next;
  logic                        rsp_valid;

  logic                        rd_en, wr_en, clearing;
  logic [ADDR_W-1:0]           rd_addr;
  logic [tlpt_pkg::DESC_W-1:0] rd_data, wr_data;
  tlpt_pkg::link_info_t        link;
  logic [TAB_W-1:0]            target;
  logic [tlpt_pkg::DESC_W-1:0] new_link, leaf;
  logic [tlpt_pkg::IDX_W-1:0]  next_idx;
  logic                        accept, rsp_free;

  tlpt_store #(
    .ADDR_W (ADDR_W),
    .DEPTH  (DEPTH)
  ) u_store (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data),
    .wr_en    (wr_en),
    .wr_addr  (addr),
    .wr_data  (wr_data),
    .clearing (clearing)
  );

  tlpt_desc #(
    .TAB_W  (TAB_W),
    .USED_W (USED_W)
  ) u_desc (
    .entry    (rd_data),
    .base     (base),
    .used     (used),
    .pa       (pa),
    .flags    (flags),
    .link     (link),
    .target   (target),
    .new_link (new_link),
    .leaf     (leaf)
  );

  assign req.ready = (state == S_IDLE) && !clearing;
  assign accept    = req.valid && req.ready;
  assign cfg.ready = 1'b1;
  assign rsp_free  = !rsp_valid || rsp.ready;
  assign rsp.valid = rsp_valid;
  assign next_idx  = (state == S_L1) ? va[29:21] : va[20:12];

  always_comb begin
    state_next      = state;
    used_next       = used;
    addr_next       = addr;
    res_status_next = res_status;
    res_pa_next     = res_pa;
    res_leaf_next   = res_leaf;
    rd_en           = 1'b0;
    rd_addr         = addr;
    wr_en           = 1'b0;
    wr_data         = '0;
    unique case (state) inside
      S_IDLE: begin
        if (accept) begin
          rd_en           = 1'b1;
          rd_addr         = {TAB_W'(0), req.virt_addr[38:30]};
          addr_next       = rd_addr;
          res_pa_next     = '0;
          res_leaf_next   = '0;
          res_status_next = tlpt_pkg::ST_UNMAPPED;
          if (req.opcode == tlpt_pkg::OP_UNUSED) begin
            state_next = S_DONE;
          end else if (req.opcode == tlpt_pkg::OP_MAP &&
                       (req.virt_addr[11:0] != 12'd0 || req.phys_addr_in[11:0] != 12'd0)) begin
            res_status_next = tlpt_pkg::ST_ALIGN;
            state_next      = S_DONE;
          end else begin
            state_next = S_L1;
          end
        end
      end
      S_L1, S_L2: begin
        if (link.present) begin
          if (link.in_range) begin
            rd_en      = 1'b1;
            rd_addr    = {target, next_idx};
            addr_next  = rd_addr;
            state_next = (state == S_L1) ? S_L2 : S_LEAF;
          end else begin
            state_next = S_DONE;
          end
        end else if (op != tlpt_pkg::OP_MAP) begin
          state_next = S_DONE;
        end else if (used >= USED_W'(MAX_TABLES)) begin
          res_status_next = tlpt_pkg::ST_NOTABLE;
          state_next      = S_DONE;
        end else begin
          // Link a fresh table here; its entries were zeroed by the sweep.
          wr_en      = 1'b1;
          wr_data    = new_link;
          used_next  = used + USED_W'(1);
          rd_en      = 1'b1;
          rd_addr    = {used[TAB_W-1:0], next_idx};
          addr_next  = rd_addr;
          state_next = (state == S_L1) ? S_L2 : S_LEAF;
        end
      end
      S_LEAF: begin
        state_next = S_DONE;
        case (op)
          tlpt_pkg::OP_MAP: begin
            wr_en           = 1'b1;
            wr_data         = leaf;
            res_status_next = tlpt_pkg::ST_OK;
            res_pa_next     = {pa[47:12], 12'b0};
            res_leaf_next   = leaf;
          end
          tlpt_pkg::OP_UNMAP: begin
            wr_en           = 1'b1;
            res_status_next = tlpt_pkg::ST_OK;
            res_leaf_next   = rd_data;
          end
          default: begin
            res_leaf_next = rd_data;
            if (rd_data[0]) begin
              res_status_next = tlpt_pkg::ST_OK;
              res_pa_next     = {rd_data[47:12], va[11:0]};
            end
          end
        endcase
      end
      S_DONE: begin
        if (rsp_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      used      <= USED_W'(1);
      base      <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      used  <= used_next;
      if (cfg.valid && cfg.ready) begin
        base <= cfg.data;
      end
      if (state == S_DONE && rsp_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    addr       <= addr_next;
    res_status <= res_status_next;
    res_pa     <= res_pa_next;
    res_leaf   <= res_leaf_next;
    if (accept) begin
      op    <= req.opcode;
      va    <= req.virt_addr;
      pa    <= req.phys_addr_in;
      flags <= req.map_flags;
    end
    if (state == S_DONE && rsp_free) begin
      rsp.status        <= res_status;
      rsp.phys_addr_out <= res_pa;
      rsp.leaf_entry    <= res_leaf;
    end
  end

  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used <= USED_W'(MAX_TABLES))
    else $error("table counter beyond the store");

  a_used_step: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (used == $past(used) || used == $past(used) + USED_W'(1)))
    else $error("table counter moved by more than one");

  a_rw_apart: assert property (@(posedge clk) disable iff (rst)
    (wr_en && rd_en) |-> (addr != rd_addr))
    else $error("read and write of one entry in the same cycle");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status != tlpt_pkg::ST_OK) |-> (rsp.phys_addr_out == '0))
    else $error("failed word carries an address");

endmodule
